[src/lcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lcc_pkg;

  localparam int Dim     = 4;
  localparam int Centers = 256;
  localparam int IdxW    = (Centers > 1) ? $clog2(Centers) : 1;
  localparam int CntW    = $clog2(Centers + 1);
  localparam int ElemW   = 16;
  localparam int DistW   = 34;
  localparam int SqW     = 2 * ElemW;

  localparam int       AddrW       = 4;
  localparam int       DataW       = 64;
  localparam bit [3:0] AddrRadius  = 4'd0;

  typedef logic [1:0] action_t;
  localparam action_t ActOffer = 2'd0;
  localparam action_t ActRead  = 2'd1;
  localparam action_t ActClear = 2'd2;

  typedef logic [ElemW-1:0] elem_t;
  typedef elem_t [3:0] vec_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] elem_0;
    logic [15:0] elem_1;
    logic [15:0] elem_2;
    logic [15:0] elem_3;
    logic [7:0]  read_index;
  } req_word_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  slot;
    logic        table_full;
    logic [8:0]  center_count;
    logic [15:0] out_elem_0;
    logic [15:0] out_elem_1;
    logic [15:0] out_elem_2;
    logic [15:0] out_elem_3;
  } rsp_word_t;

  typedef struct packed {
    logic load;
    logic scan_issue;
    logic read_issue;
    logic emit;
  } lcc_cmd_t;

  typedef struct packed {
    logic scan_left;
    logic pipe_busy;
  } lcc_stat_t;

endpackage

`default_nettype wire

[src/lcc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module lcc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  lcc_pkg::req_word_t          req,
  input  logic [lcc_pkg::DistW-1:0]   radius_squared,
  input  lcc_pkg::lcc_cmd_t           cmd,
  output lcc_pkg::lcc_stat_t          stat,
  output lcc_pkg::rsp_word_t          rsp
);
  import lcc_pkg::*;

  vec_t              mem [Centers];
  vec_t              vec;
  action_t           action;
  logic [7:0]        read_index;
  logic [CntW-1:0]   count;
  logic [CntW-1:0]   count_next;
  logic [CntW-1:0]   idx;
  vec_t              rd_data;
  logic [IdxW-1:0]   rd_addr;
  logic              rd_en;
  logic              v1;
  logic              v2;
  logic [SqW-1:0]    sq [4];
  logic [DistW-1:0]  sq_sum;
  logic              blocked;
  logic              do_write;
  logic              in_range;
  rsp_word_t         rsp_next;
  vec_t              req_vec;

  assign req_vec = {req.elem_3, req.elem_2, req.elem_1, req.elem_0};

  assign rd_en   = cmd.scan_issue | cmd.read_issue;
  assign rd_addr = cmd.scan_issue ? idx[IdxW-1:0] : IdxW'(read_index);

  assign stat.scan_left = (idx < count);
  assign stat.pipe_busy = v1 | v2;

  always_comb begin
    sq_sum = '0;
    for (int k = 0; k < 4; k++) begin
      sq_sum = sq_sum + DistW'(sq[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 4; k++) begin
        vec[k] <= (k < Dim) ? req_vec[k] : '0;
      end
      action     <= req.action;
      read_index <= req.read_index;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (v1) begin
      for (int k = 0; k < 4; k++) begin
        if (vec[k] > rd_data[k]) begin
          sq[k] <= (vec[k] - rd_data[k]) * (vec[k] - rd_data[k]);
        end else begin
          sq[k] <= (rd_data[k] - vec[k]) * (rd_data[k] - vec[k]);
        end
      end
    end
    if (do_write) begin
      mem[count[IdxW-1:0]] <= vec;
    end
    if (cmd.emit) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      idx     <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      blocked <= 1'b0;
    end else begin
      v1 <= cmd.scan_issue;
      v2 <= v1;
      if (cmd.load) begin
        idx     <= '0;
        blocked <= 1'b0;
      end else begin
        if (cmd.scan_issue) begin
          idx <= idx + 1'b1;
        end
        if (v2 && (sq_sum < radius_squared)) begin
          blocked <= 1'b1;
        end
      end
      if (cmd.emit) begin
        count <= count_next;
      end
    end
  end

  assign in_range = ({1'b0, read_index} < count);

  always_comb begin
    rsp_next   = '0;
    count_next = count;
    do_write   = 1'b0;
    case (action)
      ActOffer: begin
        if (!blocked) begin
          if (count < CntW'(Centers)) begin
            do_write          = cmd.emit;
            rsp_next.accepted = 1'b1;
            rsp_next.slot     = 8'(count);
            count_next        = count + 1'b1;
          end else begin
            rsp_next.table_full = 1'b1;
          end
        end
      end
      ActRead: begin
        rsp_next.slot = read_index;
        if (in_range) begin
          rsp_next.out_elem_0 = rd_data[0];
          rsp_next.out_elem_1 = rd_data[1];
          rsp_next.out_elem_2 = rd_data[2];
          rsp_next.out_elem_3 = rd_data[3];
        end
      end
      ActClear: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
    rsp_next.center_count = 9'(count_next);
  end

endmodule

`default_nettype wire

[src/lcc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module lcc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  lcc_pkg::action_t    req_action,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  lcc_pkg::lcc_stat_t  stat,
  output lcc_pkg::lcc_cmd_t   cmd
);
  import lcc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_READ,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && req_valid;
    cmd.scan_issue = (state == S_SCAN) && stat.scan_left;
    cmd.read_issue = (state == S_READ);
    cmd.emit       = (state == S_EMIT) && (!rsp_valid || !rsp_stall);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req_action)
            ActOffer: state_next = S_SCAN;
            ActRead:  state_next = S_READ;
            default:  state_next = S_EMIT;
          endcase
        end
      end
      S_SCAN: begin
        if (!stat.scan_left) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = S_EMIT;
        end
      end
      S_READ: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (cmd.emit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[src/leader_clustering_centers_core.sv]
// Leader clustering of RBF centers over a table of stored vectors.
// The request channel (req, req_valid, req_stall) carries one word per
// operation: offer a vector, read a stored center, or clear the table.
// The response channel (rsp, rsp_valid, rsp_stall) returns exactly one word
// per request, in order. The APB port holds radius_squared at address 0;
// write it only while the block is idle.
// An offer compares the vector with every stored center, one center per
// cycle through a three-stage distance pipeline, which drains before the
// response. A read first fetches the stored center; a clear or unused
// action goes straight to the response. One request is in work at a time;
// req_stall is high from acceptance until the response is registered.
// A new request is taken while the previous response waits in the output
// register; if rsp_stall holds that register, the next response waits in
// its final state. Synchronous reset empties the table (count zero), sets
// the radius to zero and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none

module leader_clustering_centers_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  lcc_pkg::req_word_t          req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output lcc_pkg::rsp_word_t          rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcc_pkg::AddrW-1:0]   paddr,
  input  logic [lcc_pkg::DataW-1:0]   pwdata,
  output logic [lcc_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import lcc_pkg::*;

  logic [DistW-1:0] radius_squared;
  lcc_cmd_t         cmd;
  lcc_stat_t        stat;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrRadius) ? DataW'(radius_squared) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_squared <= '0;
    end else if (psel && penable && pwrite && (paddr == AddrRadius)) begin
      radius_squared <= pwdata[DistW-1:0];
    end
  end

  lcc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_action (req.action),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  lcc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .radius_squared (radius_squared),
    .cmd            (cmd),
    .stat           (stat),
    .rsp            (rsp)
  );

endmodule

`default_nettype wire
